// ===== sv/alss_pkg.sv =====
// ---------------------------------------------------------------------------
// alss_pkg
// Shared types and constants of the adjacency list store.
// ---------------------------------------------------------------------------
`default_nettype none

package alss_pkg;

   localparam int ID_W        = 11;
   localparam int EDGE_W      = 14;
   localparam int CMD_W       = 2;
   localparam int NODES_DEF   = 1024;
   localparam int DEGREE_DEF  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [ID_W-1:0] NODE_COUNT_RST = 11'd1024;

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SWAP  = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_ADD,
      OP_ADD_SELF,
      OP_QUERY,
      OP_SWAP,
      OP_NOP,
      OP_RANGE
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [ID_W-1:0] a_id;
      logic [ID_W-1:0] b_id;
   } entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_DECIDE,
      ST_ADD_WA,
      ST_ADD_WB,
      ST_QRY,
      ST_SW_RA,
      ST_SW_RB,
      ST_SW_WA,
      ST_SW_WB,
      ST_SW_MA,
      ST_SW_MB,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== sv/alss_front.sv =====
// ---------------------------------------------------------------------------
// alss_front
// Accepts request words, checks node ids and classifies the command.
// ---------------------------------------------------------------------------
`default_nettype none

module alss_front #(
   parameter int MAX_NODES = alss_pkg::NODES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [alss_pkg::CMD_W-1:0] req_cmd,
   input  wire logic [alss_pkg::ID_W-1:0]  req_node_a,
   input  wire logic [alss_pkg::ID_W-1:0]  req_node_b,
   input  wire logic                       csr_we,
   input  wire logic [alss_pkg::ID_W-1:0]  csr_node_count,
   input  wire logic                       q_full,
   output logic                            q_push,
   output alss_pkg::entry_type             q_entry
);
   import alss_pkg::*;

   logic [ID_W-1:0] node_count_ff;
   logic            a_ok;
   logic            b_ok;

   // node count register
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
      end else if (csr_we) begin
         node_count_ff <= csr_node_count;
      end
   end

   // id range check
   assign a_ok = (req_node_a != '0) && (req_node_a <= node_count_ff)
                 && (32'(req_node_a) <= 32'(MAX_NODES));
   assign b_ok = (req_node_b != '0) && (req_node_b <= node_count_ff)
                 && (32'(req_node_b) <= 32'(MAX_NODES));

   // classify
   always_comb begin
      q_entry.a_id = req_node_a;
      q_entry.b_id = req_node_b;
      q_entry.op   = OP_NOP;
      if (req_cmd != CMD_ADD && req_cmd != CMD_QUERY && req_cmd != CMD_SWAP) begin
         q_entry.op = OP_NOP;
      end else if (!a_ok || !b_ok) begin
         q_entry.op = OP_RANGE;
      end else begin
         case (req_cmd)
            CMD_ADD:   q_entry.op = (req_node_a == req_node_b) ? OP_ADD_SELF : OP_ADD;
            CMD_QUERY: q_entry.op = OP_QUERY;
            CMD_SWAP:  q_entry.op = (req_node_a == req_node_b) ? OP_NOP : OP_SWAP;
            default:   q_entry.op = OP_NOP;
         endcase
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

`default_nettype wire

// ===== sv/alss_queue.sv =====
// ---------------------------------------------------------------------------
// alss_queue
// Short queue of classified words between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module alss_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire alss_pkg::entry_type  push_entry,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      not_empty,
   output alss_pkg::entry_type       pop_entry
);
   import alss_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff;
   logic [PW-1:0]   rd_ff;
   logic [CW-1:0]   cnt_ff;

   assign full      = (cnt_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_entry = mem_ff[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/alss_back.sv =====
// ---------------------------------------------------------------------------
// alss_back
// Carries out add, query and swap on the slot maps, degrees and neighbor
// store, and holds the response word.
// ---------------------------------------------------------------------------
`default_nettype none

module alss_back #(
   parameter int MAX_NODES  = alss_pkg::NODES_DEF,
   parameter int MAX_DEGREE = alss_pkg::DEGREE_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_not_empty,
   input  wire alss_pkg::entry_type         q_entry,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_found,
   output logic [1:0]                       rsp_status,
   output logic [alss_pkg::EDGE_W-1:0]      rsp_edge_count
);
   import alss_pkg::*;

   localparam int SW  = $clog2(MAX_NODES);
   localparam int DGW = $clog2(MAX_DEGREE + 1);
   localparam int AW  = $clog2(MAX_NODES * MAX_DEGREE);

   state_type        state_ff, state_in;
   entry_type        entry_ff;
   logic [SW-1:0]    sa_ff, sb_ff;
   logic [DGW-1:0]   da_ff, db_ff;
   logic [DGW-1:0]   i_ff;
   logic             chk_ff;
   logic [ID_W-1:0]  tmp_ff;
   logic             found_ff;
   status_type       status_ff;
   logic [EDGE_W-1:0] edge_ff;
   logic             rsp_valid_ff;
   logic [SW-1:0]    clr_ff;

   logic [SW-1:0]    slot_mem [MAX_NODES];
   logic [SW-1:0]    nos_mem  [MAX_NODES];
   logic [DGW-1:0]   deg_mem  [MAX_NODES];
   logic [ID_W-1:0]  nbr_mem  [MAX_NODES * MAX_DEGREE];
   logic [SW-1:0]    slot_q;
   logic [DGW-1:0]   deg_q;
   logic [ID_W-1:0]  nbr_q;

   logic [SW-1:0]    map_raddr;
   logic             slot_we, deg_we, nos_we, nbr_we;
   logic [SW-1:0]    slot_waddr, slot_wdata, nos_waddr, nos_wdata, deg_waddr;
   logic [DGW-1:0]   deg_wdata;
   logic [AW-1:0]    nbr_raddr, nbr_waddr;
   logic [ID_W-1:0]  nbr_wdata;

   logic [31:0]      a_m1, b_m1;
   logic [SW-1:0]    ai, bi;
   logic             is_self;
   logic             add_full;
   logic             qry_hit;

   function automatic logic [AW-1:0] nbr_addr(input logic [SW-1:0] slot,
                                              input logic [DGW-1:0] idx);
      nbr_addr = AW'(slot) * AW'(MAX_DEGREE) + AW'(idx);
   endfunction

   // node ids to table indexes
   assign a_m1    = 32'(entry_ff.a_id) - 32'd1;
   assign b_m1    = 32'(entry_ff.b_id) - 32'd1;
   assign ai      = a_m1[SW-1:0];
   assign bi      = b_m1[SW-1:0];
   assign is_self = (entry_ff.op == OP_ADD_SELF);
   assign qry_hit = chk_ff && (nbr_q == entry_ff.b_id);

   // full list check, b degree arrives in the decide step
   always_comb begin
      if (is_self) begin
         add_full = ({1'b0, da_ff} + (DGW+1)'(2)) > (DGW+1)'(MAX_DEGREE);
      end else begin
         add_full = (da_ff >= DGW'(MAX_DEGREE)) || (deg_q >= DGW'(MAX_DEGREE));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SW'(MAX_NODES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_not_empty && !rsp_valid_ff) begin
               if (q_entry.op == OP_RANGE || q_entry.op == OP_NOP) state_in = ST_DONE;
               else state_in = ST_RD_A;
            end
         end
         ST_RD_A:  state_in = ST_RD_B;
         ST_RD_B:  state_in = ST_DECIDE;
         ST_DECIDE: begin
            case (entry_ff.op)
               OP_ADD, OP_ADD_SELF: state_in = add_full ? ST_DONE : ST_ADD_WA;
               OP_QUERY:            state_in = ST_QRY;
               OP_SWAP:             state_in = ST_SW_RA;
               default:             state_in = ST_DONE;
            endcase
         end
         ST_ADD_WA: state_in = ST_ADD_WB;
         ST_ADD_WB: state_in = ST_DONE;
         ST_QRY: begin
            if (qry_hit || i_ff == da_ff) state_in = ST_DONE;
         end
         ST_SW_RA: state_in = ST_SW_RB;
         ST_SW_RB: state_in = ST_SW_WA;
         ST_SW_WA: state_in = ST_SW_WB;
         ST_SW_WB: begin
            state_in = (i_ff == DGW'(MAX_DEGREE - 1)) ? ST_SW_MA : ST_SW_RA;
         end
         ST_SW_MA: state_in = ST_SW_MB;
         ST_SW_MB: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      q_pop      = 1'b0;
      map_raddr  = ai;
      slot_we    = 1'b0;
      slot_waddr = ai;
      slot_wdata = sb_ff;
      nos_we     = 1'b0;
      nos_waddr  = sb_ff;
      nos_wdata  = ai;
      deg_we     = 1'b0;
      deg_waddr  = ai;
      deg_wdata  = da_ff + 1'b1;
      nbr_raddr  = nbr_addr(sa_ff, i_ff);
      nbr_we     = 1'b0;
      nbr_waddr  = nbr_addr(sa_ff, i_ff);
      nbr_wdata  = nbr_q;
      case (state_ff)
         ST_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            slot_wdata = clr_ff;
            nos_we     = 1'b1;
            nos_waddr  = clr_ff;
            nos_wdata  = clr_ff;
            deg_we     = 1'b1;
            deg_waddr  = clr_ff;
            deg_wdata  = '0;
         end
         ST_IDLE: begin
            q_pop = q_not_empty && !rsp_valid_ff;
         end
         ST_RD_B: begin
            map_raddr = bi;
         end
         ST_ADD_WA: begin
            nbr_we    = 1'b1;
            nbr_waddr = nbr_addr(sa_ff, da_ff);
            nbr_wdata = entry_ff.b_id;
            deg_we    = 1'b1;
            deg_waddr = ai;
            deg_wdata = is_self ? da_ff + DGW'(2) : da_ff + DGW'(1);
         end
         ST_ADD_WB: begin
            nbr_we    = 1'b1;
            nbr_waddr = is_self ? nbr_addr(sa_ff, da_ff + DGW'(1)) : nbr_addr(sb_ff, db_ff);
            nbr_wdata = entry_ff.a_id;
            deg_we    = 1'b1;
            deg_waddr = bi;
            deg_wdata = is_self ? da_ff + DGW'(2) : db_ff + DGW'(1);
         end
         ST_SW_RB: begin
            nbr_raddr = nbr_addr(sb_ff, i_ff);
         end
         ST_SW_WA: begin
            nbr_we    = 1'b1;
            nbr_waddr = nbr_addr(sa_ff, i_ff);
            nbr_wdata = nbr_q;
         end
         ST_SW_WB: begin
            nbr_we    = 1'b1;
            nbr_waddr = nbr_addr(sb_ff, i_ff);
            nbr_wdata = tmp_ff;
         end
         ST_SW_MA: begin
            slot_we    = 1'b1;
            slot_waddr = ai;
            slot_wdata = sb_ff;
            nos_we     = 1'b1;
            nos_waddr  = sb_ff;
            nos_wdata  = ai;
         end
         ST_SW_MB: begin
            slot_we    = 1'b1;
            slot_waddr = bi;
            slot_wdata = sa_ff;
            nos_we     = 1'b1;
            nos_waddr  = sa_ff;
            nos_wdata  = bi;
         end
         default: begin
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
      if (nos_we)  nos_mem[nos_waddr]   <= nos_wdata;
      if (deg_we)  deg_mem[deg_waddr]   <= deg_wdata;
      if (nbr_we)  nbr_mem[nbr_waddr]   <= nbr_wdata;
      slot_q <= slot_mem[map_raddr];
      deg_q  <= deg_mem[map_raddr];
      nbr_q  <= nbr_mem[nbr_raddr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         edge_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == ST_DONE) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_ADD_WB && edge_ff != '1) edge_ff <= edge_ff + 1'b1;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               entry_ff  <= q_entry;
               found_ff  <= 1'b0;
               status_ff <= (q_entry.op == OP_RANGE) ? STATUS_RANGE : STATUS_OK;
               i_ff      <= '0;
               chk_ff    <= 1'b0;
            end
         end
         ST_RD_B: begin
            sa_ff <= slot_q;
            da_ff <= deg_q;
         end
         ST_DECIDE: begin
            sb_ff <= slot_q;
            db_ff <= deg_q;
            if ((entry_ff.op == OP_ADD || entry_ff.op == OP_ADD_SELF) && add_full) begin
               status_ff <= STATUS_FULL;
            end
         end
         ST_QRY: begin
            if (qry_hit) begin
               found_ff <= 1'b1;
            end else if (i_ff != da_ff) begin
               i_ff   <= i_ff + 1'b1;
               chk_ff <= 1'b1;
            end
         end
         ST_SW_RB: tmp_ff <= nbr_q;
         ST_SW_WB: i_ff   <= i_ff + 1'b1;
         default: begin
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_status     = status_ff;
   assign rsp_edge_count = edge_ff;

   // a word leaves the queue only when no response is pending
   a_pop_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!rsp_valid_ff && state_ff == ST_IDLE))
      else $error("pop while response pending");

   // edge count only moves up
   a_edge_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> edge_ff >= $past(edge_ff))
      else $error("edge count went down");

   // found only for queries
   a_found_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && found_ff) |-> (entry_ff.op == OP_QUERY))
      else $error("found set outside query");

endmodule

`default_nettype wire

// ===== sv/adjacency_list_store_core.sv =====
// ---------------------------------------------------------------------------
// adjacency_list_store_core
// Undirected graph store with a fixed neighbor list per node.
// ---------------------------------------------------------------------------
// After reset a clearing pass over all MAX_NODES nodes sets the slot maps to
// identity and the degrees to zero; requests queue up meanwhile. Each request
// gives one response word. The back end walks the neighbor store one entry
// at a time for queries and swaps. One item is worked on at a time and the
// next starts only once the response word has been taken; the front end and
// a two-word queue keep accepting while the back end is busy, until the
// queue is full.
`default_nettype none

module adjacency_list_store_core #(
   parameter int MAX_NODES  = alss_pkg::NODES_DEF,
   parameter int MAX_DEGREE = alss_pkg::DEGREE_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [alss_pkg::CMD_W-1:0]  req_cmd,
   input  wire logic [alss_pkg::ID_W-1:0]   req_node_a,
   input  wire logic [alss_pkg::ID_W-1:0]   req_node_b,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_found,
   output logic [1:0]                       rsp_status,
   output logic [alss_pkg::EDGE_W-1:0]      rsp_edge_count,
   input  wire logic                        csr_we,
   input  wire logic [alss_pkg::ID_W-1:0]   csr_node_count
);
   import alss_pkg::*;

   logic      q_full, q_push, q_pop, q_not_empty;
   entry_type push_entry, pop_entry;

   alss_front #(.MAX_NODES(MAX_NODES)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_node_a     (req_node_a),
      .req_node_b     (req_node_b),
      .csr_we         (csr_we),
      .csr_node_count (csr_node_count),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   alss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .pop_entry  (pop_entry)
   );

   alss_back #(.MAX_NODES(MAX_NODES), .MAX_DEGREE(MAX_DEGREE)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_entry        (pop_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_edge_count (rsp_edge_count)
   );

endmodule

`default_nettype wire
